// ----- design/wrpt_pkg.sv -----
package wrpt_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned WGT_W  = 16;
  localparam int unsigned RAND_W = 31;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned STAT_W = 2;

  // Width of the counter of the remainder steps of the modulo.
  localparam int unsigned BIT_CNT_W = $clog2(RAND_W);

  localparam int unsigned ENTRIES_DEFAULT = 32;

  // Function codes.
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DRAW   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SYM_W-1:0]  symbol_in;
    logic [WGT_W-1:0]  weight_in;
    logic [RAND_W-1:0] random_value;
  } wrpt_in_t;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol_out;
    logic [STAT_W-1:0] status;
  } wrpt_out_t;

endpackage

// ----- design/weighted_random_pick_table_core.sv -----
// Channel   Ports                 Direction  Transaction taken when
// -------   --------------------  ---------  ------------------------------------
// command   start, busy, cmd      in         rising edge with start high, busy low
// result    done, result          out        rising edge ending the cycle done is high
//
// Append, clear, the unused function code and a draw from an empty pool give their result
// in the cycle after the command is taken, and a new command can be taken in that cycle.
// A draw from a non-empty pool first runs one restoring remainder step per random bit
// and then scans the entries, one cycle per entry scanned, up to the chosen one, both
// on a single shared subtractor. Busy is high throughout.
// Reset (rst, synchronous, active high) empties the table; the entry memory itself is
// not cleared and needs no clearing pass. The receiver cannot stall the result.
module weighted_random_pick_table_core #(
  parameter int unsigned ENTRIES = wrpt_pkg::ENTRIES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  wrpt_pkg::wrpt_in_t  cmd,
  output logic                done,
  output wrpt_pkg::wrpt_out_t result
);
  import wrpt_pkg::*;

  // Widths that follow from the table depth.
  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  // The total holds ENTRIES full-scale weights without wrapping.
  localparam int unsigned TOT_W = WGT_W + $clog2(ENTRIES);
  localparam int unsigned SUB_W = TOT_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_SCAN
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     count;
  logic [TOT_W-1:0]     total;
  logic [TOT_W-1:0]     rem;
  logic [RAND_W-1:0]    dividend;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     idx_next;

  logic                 accept;
  logic                 full;
  logic                 pool_empty;
  logic                 last_entry;
  logic                 draw_begin;
  logic                 scan_step;

  logic [SUB_W-1:0]     sub_a;
  logic [SUB_W-1:0]     sub_b;
  logic [SUB_W-1:0]     sub_diff;
  logic                 sub_borrow;

  logic [SYM_W-1:0]     rd_sym;
  logic [WGT_W-1:0]     rd_wgt;
  logic                 wr_en;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign full       = (count == CNT_W'(ENTRIES));
  assign pool_empty = (count == '0) || (total == '0);
  assign last_entry = ((CNT_W'(idx) + 1'b1) == count);
  assign wr_en      = accept && (cmd.func == FUNC_APPEND) && !full;
  assign draw_begin = accept && (cmd.func == FUNC_DRAW) && !pool_empty;
  // The scan moves on when the remainder is still at least the current weight and the current entry is not the last.
  assign scan_step  = (state == S_SCAN) && !sub_borrow && !last_entry;

  // The one subtractor serves both phases. During the modulo it tries the divisor
  // against the remainder with the next dividend bit shifted in; during the scan it
  // takes the current entry's weight off the remainder.
  always_comb begin
    if (state == S_MOD) begin
      sub_a = {rem, dividend[RAND_W-1]};
      sub_b = {1'b0, total};
    end else begin
      sub_a = {1'b0, rem};
      sub_b = SUB_W'(rd_wgt);
    end
  end

  // The read address runs one step ahead of idx, so that the registered read data
  // always belongs to the entry that idx points at.
  always_comb begin
    idx_next = idx;
    if (draw_begin) begin
      idx_next = '0;
    end else if (scan_step) begin
      idx_next = idx + 1'b1;
    end
  end

  wrpt_sub #(
    .W (SUB_W)
  ) u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  wrpt_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_sym  (cmd.symbol_in),
    .wr_wgt  (cmd.weight_in),
    .rd_addr (idx_next),
    .rd_sym  (rd_sym),
    .rd_wgt  (rd_wgt)
  );

  // Sequencer, table bookkeeping and the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      total <= '0;
      done  <= 1'b0;
      idx   <= '0;
    end else begin
      idx  <= idx_next;
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            done              <= 1'b1;
            result.symbol_out <= '0;
            result.status     <= ST_OK;
            case (cmd.func)
              FUNC_APPEND: begin
                if (full) begin
                  result.status <= ST_FULL;
                end else begin
                  count <= count + 1'b1;
                  total <= total + TOT_W'(cmd.weight_in);
                end
              end
              FUNC_DRAW: begin
                if (pool_empty) begin
                  result.status <= ST_EMPTY;
                end else begin
                  // The result is given at the end of the scan instead.
                  done     <= 1'b0;
                  rem      <= '0;
                  dividend <= cmd.random_value;
                  bit_cnt  <= '0;
                  state    <= S_MOD;
                end
              end
              FUNC_CLEAR: begin
                count <= '0;
                total <= '0;
              end
              default: begin
                // The unused code changes nothing and reports success.
              end
            endcase
          end
        end
        S_MOD: begin
          // Restoring remainder step, most significant dividend bit first.
          if (sub_borrow) begin
            rem <= sub_a[TOT_W-1:0];
          end else begin
            rem <= sub_diff[TOT_W-1:0];
          end
          dividend <= {dividend[RAND_W-2:0], 1'b0};
          bit_cnt  <= bit_cnt + 1'b1;
          if (bit_cnt == BIT_CNT_W'(RAND_W - 1)) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sub_borrow) begin
            // The remainder falls inside this entry's weight: it is the pick.
            result.symbol_out <= rd_sym;
            result.status     <= ST_OK;
            done              <= 1'b1;
            state             <= S_IDLE;
          end else if (last_entry) begin
            // Cannot happen while the total matches the stored weights.
            result.symbol_out <= '0;
            result.status     <= ST_OK;
            done              <= 1'b1;
            state             <= S_IDLE;
          end else begin
            rem <= sub_diff[TOT_W-1:0];
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result is only ever shown once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while the sequencer is still working");

  // Every command other than a draw completes in the next cycle.
  a_short_cmd: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd.func != FUNC_DRAW)) |=> done)
    else $error("single-cycle command gave no result");

  // The table never holds more entries than it has room for.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("entry count beyond table depth");

  // A refused append is reported only when the table really is full.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_FULL)) |-> full)
    else $error("table-full status with room left");

endmodule

// ----- design/wrpt_sub.sv -----
// Shared subtractor: gives a - b and a borrow flag, which is set when a < b.
module wrpt_sub #(
  parameter int unsigned W = 22
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         borrow
);

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

// ----- design/wrpt_store.sv -----
// Entry memory: one write port for appends, one registered read port for the scan.
module wrpt_store #(
  parameter int unsigned ENTRIES = wrpt_pkg::ENTRIES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(ENTRIES)-1:0]       wr_addr,
  input  logic [wrpt_pkg::SYM_W-1:0]       wr_sym,
  input  logic [wrpt_pkg::WGT_W-1:0]       wr_wgt,
  input  logic [$clog2(ENTRIES)-1:0]       rd_addr,
  output logic [wrpt_pkg::SYM_W-1:0]       rd_sym,
  output logic [wrpt_pkg::WGT_W-1:0]       rd_wgt
);
  import wrpt_pkg::*;

  logic [SYM_W+WGT_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_sym, wr_wgt};
    end
    {rd_sym, rd_wgt} <= mem[rd_addr];
  end

endmodule
